// ----- rtl/core/tcp_passive_connection_engine_core_defines.svh -----
// Assertion macros for the TCP connection engine core.
// Used by the engine modules; no other dependencies.
`ifndef TCP_PASSIVE_CONNECTION_ENGINE_CORE_DEFINES_SVH
`define TCP_PASSIVE_CONNECTION_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TPCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define TPCE_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define TPCE_ASSERT(label, clk, rst_n, prop)
`define TPCE_ASSERT_NR(label, clk, prop)
`endif
`endif

// ----- rtl/core/tpce_pkg.sv -----
// Package of the TCP connection engine: flag, phase and error codes, sizes.
// No dependencies.
package tpce_pkg;
    localparam int DefaultMaxConnections = 16;
    localparam logic [15:0] DefaultReceiveWindow = 16'd8192;
    localparam logic [3:0] SlotMask = 4'hf;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_PSH = 8'h08;
    localparam logic [7:0] FL_ACK = 8'h10;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_SYNRCVD = 2'd1;
    localparam logic [1:0] PH_ESTAB = 2'd2;
    localparam logic [1:0] PH_CLOSEWAIT = 2'd3;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_HANDSHAKE = 3'd1;
    localparam logic [2:0] ERR_RST_WINDOW = 3'd2;
    localparam logic [2:0] ERR_FLAGS = 3'd3;
    localparam logic [2:0] ERR_FULL = 3'd4;

    // Result of the table scan, passed from the search unit to the sequencer.
    typedef struct packed {
        logic done;
        logic found;
        logic free_found;
    } scan_status_t;
endpackage

// ----- rtl/core/tcp_passive_connection_engine_core.sv -----
// The key scan compares one slot a cycle through the shared comparator; after
// it come the slot read, the execute step and the result register, in that order.
// A new item is accepted only after the previous result has been taken.
// Reset empties the table at once through per-slot valid bits, window 8192.
// Top level of the TCP connection engine: sequencer, connection table, result.
// Depends on tpce_pkg, tpce_scan and the assertion header.
`include "tcp_passive_connection_engine_core_defines.svh"
module tcp_passive_connection_engine_core #(
    parameter int MAX_CONNECTIONS = tpce_pkg::DefaultMaxConnections
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] src_ip,
    input  logic [31:0] dst_ip,
    input  logic [15:0] remote_port,
    input  logic [15:0] local_port,
    input  logic [7:0]  seg_flags,
    input  logic [31:0] seg_seq,
    input  logic [31:0] seg_ack,
    input  logic [15:0] peer_window,
    input  logic [15:0] payload_len,
    input  logic [31:0] fresh_iss,
    input  logic [10:0] response_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        reply_valid,
    output logic [7:0]  reply_flags,
    output logic [31:0] reply_seq,
    output logic [31:0] reply_ack,
    output logic [15:0] reply_window,
    output logic [3:0]  conn_slot,
    output logic [1:0]  conn_phase,
    output logic [2:0]  error_code
);
    localparam int SlotW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] rwin_reg;
    logic [MAX_CONNECTIONS-1:0] valid_reg;

    // Latched item.
    logic [95:0] key_reg;
    logic [7:0]  fl_reg;
    logic [31:0] seq_reg, ack_reg, iss_reg;
    logic [15:0] pwin_reg, plen_reg;
    logic [10:0] rlen_reg;

    // Connection table memories.
    logic [95:0] key_mem [MAX_CONNECTIONS];
    logic [1:0]  ph_mem [MAX_CONNECTIONS];
    logic [31:0] rnxt_mem [MAX_CONNECTIONS];
    logic [31:0] rini_mem [MAX_CONNECTIONS];
    logic [31:0] snxt_mem [MAX_CONNECTIONS];
    logic [31:0] suna_mem [MAX_CONNECTIONS];
    logic [31:0] sini_mem [MAX_CONNECTIONS];
    logic [15:0] spw_mem [MAX_CONNECTIONS];

    logic [SlotW-1:0] scan_addr, hit_slot, free_slot;
    logic [95:0] scan_key_reg;
    tpce_pkg::scan_status_t scan_st;
    logic scan_start;

    logic [1:0]  ph_rd_reg;
    logic [31:0] rnxt_rd_reg, snxt_rd_reg;
    logic        found_reg;

    logic        ov_reg;
    logic        rv_reg, rv_next;
    logic [7:0]  rf_reg, rf_next;
    logic [31:0] rs_reg, rs_next;
    logic [31:0] ra_reg, ra_next;
    logic [15:0] rw_reg, rw_next;
    logic [3:0]  cs_reg, cs_next;
    logic [1:0]  cp_reg, cp_next;
    logic [2:0]  ec_reg, ec_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign scan_start = in_valid && in_ready;

    tpce_scan #(.MaxConnections(MAX_CONNECTIONS), .SlotW(SlotW)) u_scan (
        .clk(clk), .rst_n(rst_n), .start(scan_start),
        .key(key_reg),
        .valid_bits(valid_reg), .rd_addr(scan_addr), .rd_key(scan_key_reg),
        .status(scan_st), .hit_slot(hit_slot), .free_slot(free_slot)
    );

    always_ff @(posedge clk)
    begin
        scan_key_reg <= key_mem[scan_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (scan_start) state_next = ST_SCAN;
            ST_SCAN: if (scan_st.done) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Decision logic for the execute step.
    logic syn, ackf, fin, rst;
    logic [31:0] rst_diff, una_ack;
    logic [31:0] a_sum;
    always_comb
    begin
        syn = fl_reg[1];
        fin = fl_reg[0];
        rst = fl_reg[2];
        ackf = fl_reg[4];
        rst_diff = seq_reg - rnxt_rd_reg;
        a_sum = seq_reg + {16'd0, plen_reg} + {31'd0, fin} + {31'd0, syn};
        una_ack = ack_reg;
    end

    logic [SlotW-1:0] s_reg;

    // Reply header, slot, phase and error code for the item in the execute step.
    always_comb
    begin
        rv_next = 1'b0;
        rf_next = '0;
        rs_next = '0;
        ra_next = '0;
        rw_next = '0;
        cs_next = '0;
        cp_next = tpce_pkg::PH_NONE;
        ec_next = tpce_pkg::ERR_OK;
        if (!found_reg)
        begin
            if (!rst && syn && !ackf)
            begin
                if (!scan_st.free_found)
                    ec_next = tpce_pkg::ERR_FULL;
                else
                begin
                    rv_next = 1'b1;
                    rf_next = tpce_pkg::FL_SYN | tpce_pkg::FL_ACK;
                    rs_next = iss_reg;
                    ra_next = seq_reg + 32'd1;
                    rw_next = rwin_reg;
                    cs_next = 4'(free_slot) & tpce_pkg::SlotMask;
                    cp_next = tpce_pkg::PH_SYNRCVD;
                end
            end
            else if (!rst && ackf)
            begin
                rv_next = 1'b1;
                rf_next = tpce_pkg::FL_RST;
                rs_next = ack_reg;
            end
            else if (!rst)
            begin
                rv_next = 1'b1;
                rf_next = tpce_pkg::FL_RST | tpce_pkg::FL_ACK;
                ra_next = a_sum;
            end
        end
        else
        begin
            cs_next = 4'(s_reg) & tpce_pkg::SlotMask;
            cp_next = ph_rd_reg;
            if (rst)
            begin
                if (rst_diff < {16'd0, rwin_reg})
                    cp_next = tpce_pkg::PH_NONE;
                else
                    ec_next = tpce_pkg::ERR_RST_WINDOW;
            end
            else
            begin
                case (ph_rd_reg)
                    tpce_pkg::PH_SYNRCVD:
                    begin
                        if (ackf && !syn)
                        begin
                            if (ack_reg == snxt_rd_reg)
                                cp_next = tpce_pkg::PH_ESTAB;
                            else
                                ec_next = tpce_pkg::ERR_HANDSHAKE;
                        end
                        else if (!(syn && !ackf))
                            ec_next = tpce_pkg::ERR_FLAGS;
                    end
                    tpce_pkg::PH_ESTAB:
                    begin
                        if (fin)
                        begin
                            rv_next = 1'b1;
                            rf_next = tpce_pkg::FL_ACK;
                            rs_next = snxt_rd_reg;
                            ra_next = seq_reg + 32'd1;
                            rw_next = rwin_reg;
                            cp_next = tpce_pkg::PH_CLOSEWAIT;
                        end
                        else if (plen_reg != 16'd0)
                        begin
                            rv_next = 1'b1;
                            rf_next = (rlen_reg != 11'd0) ?
                                      (tpce_pkg::FL_PSH | tpce_pkg::FL_ACK) : tpce_pkg::FL_ACK;
                            rs_next = snxt_rd_reg;
                            ra_next = rnxt_rd_reg + {16'd0, plen_reg};
                            rw_next = rwin_reg;
                        end
                    end
                    default:
                        cp_next = ph_rd_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rwin_reg <= tpce_pkg::DefaultReceiveWindow;
            valid_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                rwin_reg <= cfg_wdata;
            if (state_reg == ST_EXEC)
            begin
                ov_reg <= 1'b1;
                if (!found_reg)
                begin
                    if (!rst && syn && !ackf && scan_st.free_found)
                        valid_reg[free_slot] <= 1'b1;
                end
                else if (rst && rst_diff < {16'd0, rwin_reg})
                    valid_reg[s_reg] <= 1'b0;
            end
            else if (state_reg == ST_OUT && out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            key_reg <= {src_ip, dst_ip, remote_port, local_port};
            fl_reg <= seg_flags;
            seq_reg <= seg_seq;
            ack_reg <= seg_ack;
            iss_reg <= fresh_iss;
            pwin_reg <= peer_window;
            plen_reg <= payload_len;
            rlen_reg <= response_len;
        end
        if (state_reg == ST_SCAN && scan_st.done)
        begin
            s_reg <= hit_slot;
            found_reg <= scan_st.found;
        end
        if (state_reg == ST_READ)
        begin
            ph_rd_reg <= ph_mem[s_reg];
            rnxt_rd_reg <= rnxt_mem[s_reg];
            snxt_rd_reg <= snxt_mem[s_reg];
        end
        if (state_reg == ST_EXEC)
        begin
            rv_reg <= rv_next;
            rf_reg <= rf_next;
            rs_reg <= rs_next;
            ra_reg <= ra_next;
            rw_reg <= rw_next;
            cs_reg <= cs_next;
            cp_reg <= cp_next;
            ec_reg <= ec_next;
            if (!found_reg)
            begin
                if (!rst && syn && !ackf && scan_st.free_found)
                begin
                    key_mem[free_slot] <= key_reg;
                    ph_mem[free_slot] <= tpce_pkg::PH_SYNRCVD;
                    rini_mem[free_slot] <= seq_reg;
                    rnxt_mem[free_slot] <= seq_reg + 32'd1;
                    spw_mem[free_slot] <= pwin_reg;
                    sini_mem[free_slot] <= iss_reg;
                    snxt_mem[free_slot] <= iss_reg + 32'd1;
                    suna_mem[free_slot] <= iss_reg;
                end
            end
            else
            begin
                if (rst)
                begin
                    if (rst_diff < {16'd0, rwin_reg})
                        ph_mem[s_reg] <= tpce_pkg::PH_NONE;
                end
                else
                begin
                    case (ph_rd_reg)
                        tpce_pkg::PH_SYNRCVD:
                        begin
                            if (syn && !ackf)
                            begin
                                rini_mem[s_reg] <= seq_reg;
                                rnxt_mem[s_reg] <= seq_reg + 32'd1;
                                spw_mem[s_reg] <= pwin_reg;
                                sini_mem[s_reg] <= iss_reg;
                                snxt_mem[s_reg] <= iss_reg + 32'd1;
                                suna_mem[s_reg] <= iss_reg;
                            end
                            else if (ackf && !syn && ack_reg == snxt_rd_reg)
                            begin
                                ph_mem[s_reg] <= tpce_pkg::PH_ESTAB;
                                suna_mem[s_reg] <= una_ack;
                            end
                        end
                        tpce_pkg::PH_ESTAB:
                        begin
                            if (fin)
                            begin
                                rnxt_mem[s_reg] <= seq_reg + 32'd1;
                                ph_mem[s_reg] <= tpce_pkg::PH_CLOSEWAIT;
                            end
                            else if (plen_reg != 16'd0)
                            begin
                                rnxt_mem[s_reg] <= rnxt_rd_reg + {16'd0, plen_reg};
                                if (rlen_reg != 11'd0)
                                    snxt_mem[s_reg] <= snxt_rd_reg + {21'd0, rlen_reg};
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign reply_valid = rv_reg;
    assign reply_flags = rf_reg;
    assign reply_seq = rs_reg;
    assign reply_ack = ra_reg;
    assign reply_window = rw_reg;
    assign conn_slot = cs_reg;
    assign conn_phase = cp_reg;
    assign error_code = ec_reg;

    `TPCE_ASSERT(a_out_only_in_out, clk, rst_n, out_valid |-> (state_reg == ST_OUT))
    `TPCE_ASSERT(a_no_accept_busy, clk, rst_n, (state_reg != ST_IDLE) |-> !in_ready)
    `TPCE_ASSERT(a_exec_then_out, clk, rst_n, (state_reg == ST_EXEC) |=> out_valid)
    `TPCE_ASSERT_NR(a_reset_empty, clk, !rst_n |-> (valid_reg == '0))
endmodule

// ----- rtl/core/tpce_scan.sv -----
// Table search unit: one shared key comparator stepped over the slots.
// Depends on tpce_pkg.
`include "tcp_passive_connection_engine_core_defines.svh"
module tpce_scan #(
    parameter int MaxConnections = tpce_pkg::DefaultMaxConnections,
    parameter int SlotW = (MaxConnections > 1) ? $clog2(MaxConnections) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [95:0]              key,
    input  logic [MaxConnections-1:0] valid_bits,
    output logic [SlotW-1:0]         rd_addr,
    input  logic [95:0]              rd_key,
    output tpce_pkg::scan_status_t   status,
    output logic [SlotW-1:0]         hit_slot,
    output logic [SlotW-1:0]         free_slot
);
    localparam logic [SlotW:0] Last = (SlotW+1)'(MaxConnections - 1);

    logic              busy_reg, busy_next;
    logic              cmp_reg, cmp_next;
    logic [SlotW:0]    idx_reg, idx_next;
    logic [SlotW-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              found_reg, found_next;
    logic              free_reg, free_next;
    logic              done_reg, done_next;
    logic [SlotW-1:0]  hit_reg, hit_next;
    logic [SlotW-1:0]  fs_reg, fs_next;

    assign rd_addr = idx_reg[SlotW-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        cmp_next = 1'b0;
        idx_next = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        found_next = found_reg;
        free_next = free_reg;
        done_next = 1'b0;
        hit_next = hit_reg;
        fs_next = fs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next = '0;
            found_next = 1'b0;
            free_next = 1'b0;
        end
        else
        begin
            // The read issued in the last cycle returns now and is compared.
            if (cmp_reg)
            begin
                if (!found_reg && valid_bits[cmp_idx_reg] && rd_key == key)
                begin
                    found_next = 1'b1;
                    hit_next = cmp_idx_reg;
                end
                if (!free_reg && !valid_bits[cmp_idx_reg])
                begin
                    free_next = 1'b1;
                    fs_next = cmp_idx_reg;
                end
                if (cmp_idx_reg == Last[SlotW-1:0])
                    done_next = 1'b1;
            end
            if (busy_reg)
            begin
                cmp_next = 1'b1;
                cmp_idx_next = idx_reg[SlotW-1:0];
                if (idx_reg == Last)
                    busy_next = 1'b0;
                else
                    idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cmp_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            free_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cmp_reg <= cmp_next;
            done_reg <= done_next;
            idx_reg <= idx_next;
            found_reg <= found_next;
            free_reg <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        hit_reg <= hit_next;
        fs_reg <= fs_next;
    end

    assign status = '{done: done_reg, found: found_reg, free_found: free_reg};
    assign hit_slot = hit_reg;
    assign free_slot = fs_reg;

    `TPCE_ASSERT(a_done_after_cmp, clk, rst_n, done_reg |-> $past(cmp_reg))
    `TPCE_ASSERT(a_no_cmp_idle, clk, rst_n, (!busy_reg && !cmp_reg) |=> !cmp_reg)
    `TPCE_ASSERT(a_done_pulse, clk, rst_n, done_reg |=> !done_reg)
endmodule
